[rtl/eas_pkg.sv]
// Character constants and classification functions for the email address checker.
package eas_pkg;

    localparam logic [7:0] CHAR_AT   = 8'h40;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_DASH = 8'h2D;

    localparam int AT_COUNT_W      = 2;
    localparam int WORD_COUNT_W    = 2;
    localparam logic [WORD_COUNT_W-1:0] MIN_DOMAIN_WORDS = WORD_COUNT_W'(2);
    localparam logic [AT_COUNT_W-1:0]   AT_COUNT_MAX     = AT_COUNT_W'(2);

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_letter(c) || is_digit(c);
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        return (c == CHAR_AT) || (c == CHAR_DOT);
    endfunction

endpackage

[rtl/email_address_syntax_check.sv]
// Streaming email address syntax checker, one character per transfer.
// A terminator passes through the input register and then the result register, which
// presents its verdict; it waits in the input register while the output is stalled.
// One character or terminator per cycle unless stalled, set by the state update.
// Reset: rst_n asynchronously empties the input and output registers and returns
// the checker to the start of an address.
module email_address_syntax_check
    import eas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       terminator,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_invalid
);

    // Input register.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_ch_reg;
    logic       s1_term_reg;

    // Address state.
    logic [7:0]              prev_char_reg, prev_char_next;
    logic                    at_start_reg, at_start_next;
    logic [AT_COUNT_W-1:0]   at_count_reg, at_count_next;
    logic                    in_domain_reg, in_domain_next;
    logic [WORD_COUNT_W-1:0] word_count_reg, word_count_next;
    logic                    error_reg, error_next;

    // Result register.
    logic out_valid_reg, out_valid_next;
    logic out_is_invalid_reg, out_is_invalid_next;

    logic in_accept;
    logic out_free;
    logic s1_advance;
    logic sep, prev_sep, char_bad, verdict;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && (!s1_term_reg || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    assign out_valid  = out_valid_reg;
    assign is_invalid = out_is_invalid_reg;

    assign sep      = is_separator(s1_ch_reg);
    assign prev_sep = !at_start_reg && is_separator(prev_char_reg);
    assign verdict  = error_reg || at_start_reg || (word_count_reg < MIN_DOMAIN_WORDS)
                      || !is_alnum(prev_char_reg);

    always_comb
    begin
        char_bad = !(is_alnum(s1_ch_reg) || (s1_ch_reg == CHAR_DASH) || sep);
        if (at_start_reg)
        begin
            char_bad = char_bad || !is_letter(s1_ch_reg);
        end
        else
        begin
            char_bad = char_bad || (prev_sep && !is_letter(s1_ch_reg))
                       || (sep && !is_alnum(prev_char_reg));
        end
        // A second '@' is an error whether or not the count has saturated.
        if ((s1_ch_reg == CHAR_AT) && (at_count_reg != '0))
        begin
            char_bad = 1'b1;
        end
    end

    always_comb
    begin
        prev_char_next  = prev_char_reg;
        at_start_next   = at_start_reg;
        at_count_next   = at_count_reg;
        in_domain_next  = in_domain_reg;
        word_count_next = word_count_reg;
        error_next      = error_reg;
        if (s1_advance)
        begin
            if (s1_term_reg)
            begin
                prev_char_next  = '0;
                at_start_next   = 1'b1;
                at_count_next   = '0;
                in_domain_next  = 1'b0;
                word_count_next = '0;
                error_next      = 1'b0;
            end
            else
            begin
                if (s1_ch_reg == CHAR_AT)
                begin
                    in_domain_next = 1'b1;
                    if (at_count_reg < AT_COUNT_MAX)
                    begin
                        at_count_next = at_count_reg + AT_COUNT_W'(1);
                    end
                end
                // A new domain word begins at the character after a separator.
                if (in_domain_next && prev_sep && (word_count_reg < MIN_DOMAIN_WORDS))
                begin
                    word_count_next = word_count_reg + WORD_COUNT_W'(1);
                end
                error_next     = error_reg || char_bad;
                prev_char_next = s1_ch_reg;
                at_start_next  = 1'b0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next       = in_accept || (s1_valid_reg && !s1_advance);
        out_valid_next      = out_valid_reg && out_stall;
        out_is_invalid_next = out_is_invalid_reg;
        if (s1_advance && s1_term_reg)
        begin
            out_valid_next      = 1'b1;
            out_is_invalid_next = verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_char_reg  <= '0;
            at_start_reg   <= 1'b1;
            at_count_reg   <= '0;
            in_domain_reg  <= 1'b0;
            word_count_reg <= '0;
            error_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            prev_char_reg  <= prev_char_next;
            at_start_reg   <= at_start_next;
            at_count_reg   <= at_count_next;
            in_domain_reg  <= in_domain_next;
            word_count_reg <= word_count_next;
            error_reg      <= error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ch_reg   <= ch;
            s1_term_reg <= terminator;
        end
        out_is_invalid_reg <= out_is_invalid_next;
    end

endmodule

[rtl/eas_checker.sv]
// Port-level checker for the email address checker, bound to the top level.
module eas_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] ch,
    input logic       terminator,
    input logic       out_valid,
    input logic       out_stall,
    input logic       is_invalid
);

    // A stalled verdict stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(is_invalid))
        else $error("stalled verdict changed or was dropped");

    // With the output empty, the input side never waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");

    // The input waits only on a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled without output stall");

    // A verdict appearing on an empty output follows a terminator transfer through both registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && terminator, 2))
        else $error("verdict without a preceding terminator");

    // A stalled input transfer holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(ch) && $stable(terminator))
        else $error("stalled input payload changed or was withdrawn");

endmodule

bind email_address_syntax_check eas_checker u_eas_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .terminator (terminator),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_invalid (is_invalid)
);
